// File: design/rti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rti_pkg;

    // coordinate format
    localparam int CW     = 32;
    localparam int FB     = 16;
    localparam int TW     = 31;

    // configuration port
    localparam int DATA_W = (CW > 32) ? 64 : 32;
    localparam int RSB    = (CW > 32) ? 3 : 2;
    localparam int AW     = RSB + 3;

    // datapath widths
    localparam int EW     = CW + 1;          // edges and origin offset
    localparam int PW     = 2 * EW;          // cross product terms
    localparam int HW     = PW + 1;          // cross product components
    localparam int HIW    = HW - EW;         // upper slice of a component
    localparam int PPW    = EW + HIW;        // partial product
    localparam int DW     = EW + HW + 2;     // determinant and numerators
    localparam int CHW    = 34;              // slice of the determinant for eps * a
    localparam int NCH    = (DW + CHW - 1) / CHW;
    localparam int APW    = NCH * CHW;
    localparam int EPW    = TW + CHW;
    localparam int EAW    = TW + APW;
    localparam int CMW    = EAW + 1;
    localparam int NW     = DW + FB;         // shifted distance numerator
    localparam int RW     = DW + TW;         // divider remainder
    localparam int PMW    = CW + TW + 1;     // direction times distance
    localparam int SUMW   = PMW - FB + 1;

    typedef enum logic [2:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_ORIGIN_Z  = 3'd2,
        REG_DIR_X     = 3'd3,
        REG_DIR_Y     = 3'd4,
        REG_DIR_Z     = 3'd5,
        REG_TOLERANCE = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [CW-1:0] v0_x;
        logic signed [CW-1:0] v0_y;
        logic signed [CW-1:0] v0_z;
        logic signed [CW-1:0] v1_x;
        logic signed [CW-1:0] v1_y;
        logic signed [CW-1:0] v1_z;
        logic signed [CW-1:0] v2_x;
        logic signed [CW-1:0] v2_y;
        logic signed [CW-1:0] v2_z;
    } tri_t;

    typedef struct packed {
        logic                 hit;
        logic [TW-1:0]        distance;
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
    } res_t;

    typedef struct packed {
        logic          valid;
        logic          hit;
        logic          sat;
        logic [RW-1:0] rem;
        logic [DW-1:0] dvs;
    } div_in_t;

    typedef struct packed {
        logic          valid;
        logic          hit;
        logic [TW-1:0] quo;
    } div_out_t;

endpackage
`default_nettype wire

// File: design/rti_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rti_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire rti_pkg::div_in_t  din,
    output rti_pkg::div_out_t      dout
);
    import rti_pkg::*;

    logic          valid_reg [TW];
    logic          hit_reg   [TW];
    logic          sat_reg   [TW];
    logic [RW-1:0] rem_reg   [TW];
    logic [DW-1:0] dvs_reg   [TW];
    logic [TW-1:0] q_reg     [TW];

    logic [RW-1:0] rem_next  [TW];
    logic [TW-1:0] q_next    [TW];

    logic          src_valid [TW+1];
    logic          src_hit   [TW+1];
    logic          src_sat   [TW+1];
    logic [RW-1:0] src_rem   [TW+1];
    logic [DW-1:0] src_dvs   [TW+1];
    logic [TW-1:0] src_q     [TW+1];

    always_comb
    begin
        src_valid[0] = din.valid;
        src_hit[0]   = din.hit;
        src_sat[0]   = din.sat;
        src_rem[0]   = din.rem;
        src_dvs[0]   = din.dvs;
        src_q[0]     = '0;
        for (int j = 0; j < TW; j++)
        begin
            src_valid[j+1] = valid_reg[j];
            src_hit[j+1]   = hit_reg[j];
            src_sat[j+1]   = sat_reg[j];
            src_rem[j+1]   = rem_reg[j];
            src_dvs[j+1]   = dvs_reg[j];
            src_q[j+1]     = q_reg[j];
        end
    end

    // one quotient bit per stage, most significant first
    always_comb
    begin
        logic [RW-1:0] sub;
        for (int j = 0; j < TW; j++)
        begin
            sub = RW'(src_dvs[j]) << (TW - 1 - j);
            if (src_rem[j] >= sub)
            begin
                rem_next[j] = src_rem[j] - sub;
                q_next[j]   = {src_q[j][TW-2:0], 1'b1};
            end
            else
            begin
                rem_next[j] = src_rem[j];
                q_next[j]   = {src_q[j][TW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < TW; j++)
            begin
                valid_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int j = 0; j < TW; j++)
            begin
                valid_reg[j] <= src_valid[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < TW; j++)
            begin
                hit_reg[j] <= src_hit[j];
                sat_reg[j] <= src_sat[j];
                rem_reg[j] <= rem_next[j];
                dvs_reg[j] <= src_dvs[j];
                q_reg[j]   <= q_next[j];
            end
        end
    end

    assign dout.valid = valid_reg[TW-1];
    assign dout.hit   = hit_reg[TW-1];
    assign dout.quo   = sat_reg[TW-1] ? '1 : q_reg[TW-1];

endmodule
`default_nettype wire

// File: design/ray_triangle_intersect.sv
`timescale 1ns / 1ps
`default_nettype none
// Moller-Trumbore test of the ray held in the configuration registers against one
// triangle per input word, in exact fixed point. The pipeline takes one word every
// cycle while the result side does not stall: nine stages form the edges, cross
// products, determinant, numerators and the hit tests, one stage loads the divider,
// 31 divider stages produce one distance bit each, and two stages form the point.
// When the result side stalls with a word waiting in the output register the whole
// pipeline holds, and the triangle side stalls with it. The user must write
// configuration only while no word is in flight; the block does not enforce it.
module ray_triangle_intersect (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rti_pkg::AW-1:0]      paddr,
    input  wire logic [rti_pkg::DATA_W-1:0]  pwdata,
    output logic [rti_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    input  wire logic                        tri_valid,
    output logic                             tri_stall,
    input  wire rti_pkg::tri_t               tri_word,
    output logic                             res_valid,
    input  wire logic                        res_stall,
    output rti_pkg::res_t                    res_word
);
    import rti_pkg::*;

    // configuration registers
    logic signed [CW-1:0] origin_reg [3];
    logic signed [CW-1:0] dir_reg    [3];
    logic [TW-1:0]        tol_reg;
    logic [2:0]           reg_sel;
    logic                 cfg_wr;

    assign reg_sel = paddr[AW-1:RSB];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                origin_reg[i] <= '0;
                dir_reg[i]    <= '0;
            end
            tol_reg <= TW'(1);
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_ORIGIN_X:  origin_reg[0] <= $signed(pwdata[CW-1:0]);
                REG_ORIGIN_Y:  origin_reg[1] <= $signed(pwdata[CW-1:0]);
                REG_ORIGIN_Z:  origin_reg[2] <= $signed(pwdata[CW-1:0]);
                REG_DIR_X:     dir_reg[0]    <= $signed(pwdata[CW-1:0]);
                REG_DIR_Y:     dir_reg[1]    <= $signed(pwdata[CW-1:0]);
                REG_DIR_Z:     dir_reg[2]    <= $signed(pwdata[CW-1:0]);
                REG_TOLERANCE: tol_reg       <= pwdata[TW-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ORIGIN_X:  prdata = DATA_W'($unsigned(origin_reg[0]));
            REG_ORIGIN_Y:  prdata = DATA_W'($unsigned(origin_reg[1]));
            REG_ORIGIN_Z:  prdata = DATA_W'($unsigned(origin_reg[2]));
            REG_DIR_X:     prdata = DATA_W'($unsigned(dir_reg[0]));
            REG_DIR_Y:     prdata = DATA_W'($unsigned(dir_reg[1]));
            REG_DIR_Z:     prdata = DATA_W'($unsigned(dir_reg[2]));
            REG_TOLERANCE: prdata = DATA_W'(tol_reg);
            default:       prdata = '0;
        endcase
    end

    // pipeline advance
    logic adv;
    logic res_valid_reg;
    res_t res_word_reg;

    assign adv       = !res_valid_reg || !res_stall;
    assign tri_stall = !adv;
    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    logic signed [CW-1:0] v0 [3];
    logic signed [CW-1:0] v1 [3];
    logic signed [CW-1:0] v2 [3];
    logic signed [EW-1:0] dx [3];

    assign v0[0] = tri_word.v0_x;
    assign v0[1] = tri_word.v0_y;
    assign v0[2] = tri_word.v0_z;
    assign v1[0] = tri_word.v1_x;
    assign v1[1] = tri_word.v1_y;
    assign v1[2] = tri_word.v1_z;
    assign v2[0] = tri_word.v2_x;
    assign v2[1] = tri_word.v2_y;
    assign v2[2] = tri_word.v2_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dx[i] = EW'(dir_reg[i]);
        end
    end

    // stage 1: edges and origin offset
    logic                 s1_valid_reg;
    logic signed [EW-1:0] s1_e1_reg [3];
    logic signed [EW-1:0] s1_e2_reg [3];
    logic signed [EW-1:0] s1_s_reg  [3];
    logic signed [EW-1:0] s1_e1_next [3];
    logic signed [EW-1:0] s1_e2_next [3];
    logic signed [EW-1:0] s1_s_next  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_e1_next[i] = EW'(v1[i]) - EW'(v0[i]);
            s1_e2_next[i] = EW'(v2[i]) - EW'(v0[i]);
            s1_s_next[i]  = EW'(origin_reg[i]) - EW'(v0[i]);
        end
    end

    // stage 2: cross product terms, h = d x e2 and q = s x e1
    logic                 s2_valid_reg;
    logic signed [PW-1:0] s2_hp_reg [6];
    logic signed [PW-1:0] s2_qp_reg [6];
    logic signed [EW-1:0] s2_e1_reg [3];
    logic signed [EW-1:0] s2_e2_reg [3];
    logic signed [EW-1:0] s2_s_reg  [3];
    logic signed [PW-1:0] s2_hp_next [6];
    logic signed [PW-1:0] s2_qp_next [6];

    always_comb
    begin
        s2_hp_next[0] = dx[1] * s1_e2_reg[2];
        s2_hp_next[1] = dx[2] * s1_e2_reg[1];
        s2_hp_next[2] = dx[2] * s1_e2_reg[0];
        s2_hp_next[3] = dx[0] * s1_e2_reg[2];
        s2_hp_next[4] = dx[0] * s1_e2_reg[1];
        s2_hp_next[5] = dx[1] * s1_e2_reg[0];
        s2_qp_next[0] = s1_s_reg[1] * s1_e1_reg[2];
        s2_qp_next[1] = s1_s_reg[2] * s1_e1_reg[1];
        s2_qp_next[2] = s1_s_reg[2] * s1_e1_reg[0];
        s2_qp_next[3] = s1_s_reg[0] * s1_e1_reg[2];
        s2_qp_next[4] = s1_s_reg[0] * s1_e1_reg[1];
        s2_qp_next[5] = s1_s_reg[1] * s1_e1_reg[0];
    end

    // stage 3: cross product components
    logic                 s3_valid_reg;
    logic signed [HW-1:0] s3_h_reg  [3];
    logic signed [HW-1:0] s3_q_reg  [3];
    logic signed [EW-1:0] s3_e1_reg [3];
    logic signed [EW-1:0] s3_e2_reg [3];
    logic signed [EW-1:0] s3_s_reg  [3];
    logic signed [HW-1:0] s3_h_next [3];
    logic signed [HW-1:0] s3_q_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s3_h_next[i] = HW'(s2_hp_reg[2*i]) - HW'(s2_hp_reg[2*i+1]);
            s3_q_next[i] = HW'(s2_qp_reg[2*i]) - HW'(s2_qp_reg[2*i+1]);
        end
    end

    // stage 4: dot product partials, components split into a low and a high slice
    logic                  s4_valid_reg;
    logic signed [PPW-1:0] s4_alo_reg [3];
    logic signed [PPW-1:0] s4_ahi_reg [3];
    logic signed [PPW-1:0] s4_ulo_reg [3];
    logic signed [PPW-1:0] s4_uhi_reg [3];
    logic signed [PPW-1:0] s4_vlo_reg [3];
    logic signed [PPW-1:0] s4_vhi_reg [3];
    logic signed [PPW-1:0] s4_tlo_reg [3];
    logic signed [PPW-1:0] s4_thi_reg [3];
    logic signed [PPW-1:0] s4_alo_next [3];
    logic signed [PPW-1:0] s4_ahi_next [3];
    logic signed [PPW-1:0] s4_ulo_next [3];
    logic signed [PPW-1:0] s4_uhi_next [3];
    logic signed [PPW-1:0] s4_vlo_next [3];
    logic signed [PPW-1:0] s4_vhi_next [3];
    logic signed [PPW-1:0] s4_tlo_next [3];
    logic signed [PPW-1:0] s4_thi_next [3];

    always_comb
    begin
        logic signed [EW:0]    hlo;
        logic signed [HIW-1:0] hhi;
        logic signed [EW:0]    qlo;
        logic signed [HIW-1:0] qhi;
        for (int i = 0; i < 3; i++)
        begin
            hlo = $signed({1'b0, s3_h_reg[i][EW-1:0]});
            hhi = $signed(s3_h_reg[i][HW-1:EW]);
            qlo = $signed({1'b0, s3_q_reg[i][EW-1:0]});
            qhi = $signed(s3_q_reg[i][HW-1:EW]);
            s4_alo_next[i] = s3_e1_reg[i] * hlo;
            s4_ahi_next[i] = s3_e1_reg[i] * hhi;
            s4_ulo_next[i] = s3_s_reg[i] * hlo;
            s4_uhi_next[i] = s3_s_reg[i] * hhi;
            s4_vlo_next[i] = dx[i] * qlo;
            s4_vhi_next[i] = dx[i] * qhi;
            s4_tlo_next[i] = s3_e2_reg[i] * qlo;
            s4_thi_next[i] = s3_e2_reg[i] * qhi;
        end
    end

    // stage 5: rejoin the slices
    logic                 s5_valid_reg;
    logic signed [DW-1:0] s5_a_reg [3];
    logic signed [DW-1:0] s5_u_reg [3];
    logic signed [DW-1:0] s5_v_reg [3];
    logic signed [DW-1:0] s5_t_reg [3];
    logic signed [DW-1:0] s5_a_next [3];
    logic signed [DW-1:0] s5_u_next [3];
    logic signed [DW-1:0] s5_v_next [3];
    logic signed [DW-1:0] s5_t_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s5_a_next[i] = (DW'(s4_ahi_reg[i]) <<< EW) + DW'(s4_alo_reg[i]);
            s5_u_next[i] = (DW'(s4_uhi_reg[i]) <<< EW) + DW'(s4_ulo_reg[i]);
            s5_v_next[i] = (DW'(s4_vhi_reg[i]) <<< EW) + DW'(s4_vlo_reg[i]);
            s5_t_next[i] = (DW'(s4_thi_reg[i]) <<< EW) + DW'(s4_tlo_reg[i]);
        end
    end

    // stage 6: determinant and numerators
    logic                 s6_valid_reg;
    logic signed [DW-1:0] s6_a_reg;
    logic signed [DW-1:0] s6_u_reg;
    logic signed [DW-1:0] s6_v_reg;
    logic signed [DW-1:0] s6_t_reg;
    logic signed [DW-1:0] s6_a_next;
    logic signed [DW-1:0] s6_u_next;
    logic signed [DW-1:0] s6_v_next;
    logic signed [DW-1:0] s6_t_next;

    assign s6_a_next = s5_a_reg[0] + s5_a_reg[1] + s5_a_reg[2];
    assign s6_u_next = s5_u_reg[0] + s5_u_reg[1] + s5_u_reg[2];
    assign s6_v_next = s5_v_reg[0] + s5_v_reg[1] + s5_v_reg[2];
    assign s6_t_next = s5_t_reg[0] + s5_t_reg[1] + s5_t_reg[2];

    // stage 7: make the determinant nonnegative
    logic                 s7_valid_reg;
    logic signed [DW-1:0] s7_a_reg;
    logic signed [DW-1:0] s7_u_reg;
    logic signed [DW-1:0] s7_v_reg;
    logic signed [DW-1:0] s7_t_reg;
    logic                 a_neg;

    assign a_neg = s6_a_reg[DW-1];

    // stage 8: parallel and barycentric tests, eps * a partials
    logic                  s8_valid_reg;
    logic                  s8_ok_reg;
    logic signed [DW-1:0]  s8_a_reg;
    logic signed [DW-1:0]  s8_t_reg;
    logic [EPW-1:0]        s8_ep_reg [NCH];
    logic                  s8_ok_next;
    logic [EPW-1:0]        s8_ep_next [NCH];

    always_comb
    begin
        logic [APW-1:0]            a_pad;
        logic signed [TW+2*FB:0]   thr;
        logic signed [DW:0]        uv;
        a_pad = APW'($unsigned(s7_a_reg));
        thr   = $signed({1'b0, tol_reg, {(2*FB){1'b0}}});
        uv    = (DW+1)'(s7_u_reg) + (DW+1)'(s7_v_reg);
        for (int c = 0; c < NCH; c++)
        begin
            s8_ep_next[c] = EPW'(tol_reg) * EPW'(a_pad[c*CHW +: CHW]);
        end
        s8_ok_next = (s7_a_reg != '0) && !(s7_a_reg < thr)
                     && !s7_u_reg[DW-1] && !(s7_u_reg > s7_a_reg)
                     && !s7_v_reg[DW-1] && !(uv > (DW+1)'(s7_a_reg));
    end

    // stage 9: eps * a
    logic                 s9_valid_reg;
    logic                 s9_ok_reg;
    logic signed [DW-1:0] s9_a_reg;
    logic signed [DW-1:0] s9_t_reg;
    logic [EAW-1:0]       s9_epsa_reg;
    logic [EAW-1:0]       s9_epsa_next;

    always_comb
    begin
        s9_epsa_next = '0;
        for (int c = 0; c < NCH; c++)
        begin
            s9_epsa_next = s9_epsa_next + (EAW'(s8_ep_reg[c]) << (c * CHW));
        end
    end

    // stage 10: distance test and divider load
    logic                 din_valid_reg;
    logic                 din_hit_reg;
    logic                 din_sat_reg;
    logic [RW-1:0]        din_rem_reg;
    logic [DW-1:0]        din_dvs_reg;
    logic                 din_hit_next;
    logic                 din_sat_next;
    logic [RW-1:0]        din_rem_next;
    logic signed [NW-1:0] lhs;
    div_in_t              din;
    div_out_t             dout;

    always_comb
    begin
        lhs          = $signed({s9_t_reg, {FB{1'b0}}});
        din_hit_next = s9_ok_reg && ($signed({1'b0, s9_epsa_reg}) < CMW'(lhs));
        din_rem_next = RW'($unsigned(lhs));
        din_sat_next = din_rem_next >= (RW'($unsigned(s9_a_reg)) << TW);
    end

    assign din.valid = din_valid_reg;
    assign din.hit   = din_hit_reg;
    assign din.sat   = din_sat_reg;
    assign din.rem   = din_rem_reg;
    assign din.dvs   = din_dvs_reg;

    rti_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .din   (din),
        .dout  (dout)
    );

    // direction times distance
    logic                  p1_valid_reg;
    logic                  p1_hit_reg;
    logic [TW-1:0]         p1_t_reg;
    logic signed [PMW-1:0] p1_pm_reg  [3];
    logic signed [PMW-1:0] p1_pm_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p1_pm_next[i] = dir_reg[i] * $signed({1'b0, dout.quo});
        end
    end

    // point with saturation, zero word on a miss
    res_t res_next;

    always_comb
    begin
        logic signed [SUMW-1:0] sum;
        logic signed [CW-1:0]   pt [3];
        logic [SUMW-CW:0]       top;
        for (int i = 0; i < 3; i++)
        begin
            sum = SUMW'($signed(p1_pm_reg[i][PMW-1:FB])) + SUMW'(origin_reg[i]);
            top = sum[SUMW-1:CW-1];
            if ((&top) || !(|top))
            begin
                pt[i] = sum[CW-1:0];
            end
            else
            begin
                pt[i] = sum[SUMW-1] ? $signed({1'b1, {(CW-1){1'b0}}})
                                    : $signed({1'b0, {(CW-1){1'b1}}});
            end
        end
        if (p1_hit_reg)
        begin
            res_next.hit      = 1'b1;
            res_next.distance = p1_t_reg;
            res_next.point_x  = pt[0];
            res_next.point_y  = pt[1];
            res_next.point_z  = pt[2];
        end
        else
        begin
            res_next = '0;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            din_valid_reg <= 1'b0;
            p1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= tri_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            s8_valid_reg  <= s7_valid_reg;
            s9_valid_reg  <= s8_valid_reg;
            din_valid_reg <= s9_valid_reg;
            p1_valid_reg  <= dout.valid;
            res_valid_reg <= p1_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_e1_reg[i] <= s1_e1_next[i];
                s1_e2_reg[i] <= s1_e2_next[i];
                s1_s_reg[i]  <= s1_s_next[i];
                s2_e1_reg[i] <= s1_e1_reg[i];
                s2_e2_reg[i] <= s1_e2_reg[i];
                s2_s_reg[i]  <= s1_s_reg[i];
                s3_h_reg[i]  <= s3_h_next[i];
                s3_q_reg[i]  <= s3_q_next[i];
                s3_e1_reg[i] <= s2_e1_reg[i];
                s3_e2_reg[i] <= s2_e2_reg[i];
                s3_s_reg[i]  <= s2_s_reg[i];
                s4_alo_reg[i] <= s4_alo_next[i];
                s4_ahi_reg[i] <= s4_ahi_next[i];
                s4_ulo_reg[i] <= s4_ulo_next[i];
                s4_uhi_reg[i] <= s4_uhi_next[i];
                s4_vlo_reg[i] <= s4_vlo_next[i];
                s4_vhi_reg[i] <= s4_vhi_next[i];
                s4_tlo_reg[i] <= s4_tlo_next[i];
                s4_thi_reg[i] <= s4_thi_next[i];
                s5_a_reg[i]  <= s5_a_next[i];
                s5_u_reg[i]  <= s5_u_next[i];
                s5_v_reg[i]  <= s5_v_next[i];
                s5_t_reg[i]  <= s5_t_next[i];
                p1_pm_reg[i] <= p1_pm_next[i];
            end
            for (int i = 0; i < 6; i++)
            begin
                s2_hp_reg[i] <= s2_hp_next[i];
                s2_qp_reg[i] <= s2_qp_next[i];
            end
            s6_a_reg <= s6_a_next;
            s6_u_reg <= s6_u_next;
            s6_v_reg <= s6_v_next;
            s6_t_reg <= s6_t_next;
            s7_a_reg <= a_neg ? -s6_a_reg : s6_a_reg;
            s7_u_reg <= a_neg ? -s6_u_reg : s6_u_reg;
            s7_v_reg <= a_neg ? -s6_v_reg : s6_v_reg;
            s7_t_reg <= a_neg ? -s6_t_reg : s6_t_reg;
            s8_ok_reg <= s8_ok_next;
            s8_a_reg  <= s7_a_reg;
            s8_t_reg  <= s7_t_reg;
            for (int c = 0; c < NCH; c++)
            begin
                s8_ep_reg[c] <= s8_ep_next[c];
            end
            s9_ok_reg   <= s8_ok_reg;
            s9_a_reg    <= s8_a_reg;
            s9_t_reg    <= s8_t_reg;
            s9_epsa_reg <= s9_epsa_next;
            din_hit_reg <= din_hit_next;
            din_sat_reg <= din_sat_next;
            din_rem_reg <= din_rem_next;
            din_dvs_reg <= $unsigned(s9_a_reg);
            p1_hit_reg  <= dout.hit;
            p1_t_reg    <= dout.quo;
            res_word_reg <= res_next;
        end
    end

endmodule
`default_nettype wire
